/* design/message_deframer_defines.svh */
// Assertion macros shared by the message deframer modules.
`ifndef MESSAGE_DEFRAMER_DEFINES_SVH
`define MESSAGE_DEFRAMER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define MDF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define MDF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/mdf_pkg.sv */
// Shared constants and result type for the message deframer.
package mdf_pkg;

   // Protocol modes
   localparam logic [1:0] MODE_DIRECT = 2'd0;
   localparam logic [1:0] MODE_LINE   = 2'd1;
   localparam logic [1:0] MODE_TELNET = 2'd2;
   localparam logic [1:0] MODE_BASIC  = 2'd3;

   // Basic header type characters
   localparam logic [7:0] CHAR_ACTION = 8'h41;
   localparam logic [7:0] CHAR_REPLY  = 8'h52;

   // Basic header length in bytes (type plus 32-bit id)
   localparam logic [2:0] HEADER_LEN  = 3'd5;
   localparam logic [2:0] HEADER_LAST = 3'd4;

   // Message kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_ACTION = 2'd1;
   localparam logic [1:0] KIND_REPLY  = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_SHORT = 2'd1;
   localparam logic [1:0] ERR_TYPE  = 2'd2;

   // One result beat
   typedef struct packed {
      logic [1:0]  error_code;
      logic [31:0] message_id;
      logic [1:0]  message_kind;
      logic        end_of_message;
      logic        byte_valid;
      logic [7:0]  payload_byte;
   } result_type;

endpackage

/* design/mdf_frame.sv */
// Framing state and per-beat strip logic for each protocol mode.
module mdf_frame (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_wdata,
   input  logic               in_fire,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   output logic               has_result,
   output mdf_pkg::result_type result
);
   import mdf_pkg::*;

   logic [1:0]  mode_ff;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic [2:0]  header_ff, header_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] id_ff, id_in;
   logic        bad_ff, bad_in;
   logic        clear;

   // Work out the result and the next per-message state
   always_comb begin
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      held_count_in = held_count_ff;
      header_in     = header_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      bad_in        = bad_ff;
      clear         = 1'b0;
      has_result    = 1'b0;
      result        = '0;
      unique case (mode_ff)
         MODE_DIRECT: begin
            has_result            = 1'b1;
            result.payload_byte   = in_byte;
            result.byte_valid     = 1'b1;
            result.end_of_message = in_last;
         end
         MODE_LINE: begin
            if (!in_last) begin
               has_result          = (held_count_ff != 2'd0);
               result.payload_byte = held0_ff;
               result.byte_valid   = 1'b1;
               held0_in            = in_byte;
               held_count_in       = 2'd1;
            end else begin
               has_result            = 1'b1;
               result.end_of_message = 1'b1;
               result.byte_valid     = (held_count_ff != 2'd0);
               result.payload_byte   = result.byte_valid ? held0_ff : 8'd0;
               clear                 = 1'b1;
            end
         end
         MODE_TELNET: begin
            if (!in_last) begin
               if (held_count_ff[1]) begin
                  // Delay line full: shift and release the oldest byte
                  has_result          = 1'b1;
                  result.payload_byte = held0_ff;
                  result.byte_valid   = 1'b1;
                  held0_in            = held1_ff;
                  held1_in            = in_byte;
               end else begin
                  if (held_count_ff[0]) begin
                     held1_in = in_byte;
                  end else begin
                     held0_in = in_byte;
                  end
                  held_count_in = held_count_ff + 2'd1;
               end
            end else begin
               has_result            = 1'b1;
               result.end_of_message = 1'b1;
               result.byte_valid     = held_count_ff[1];
               result.payload_byte   = held_count_ff[1] ? held0_ff : 8'd0;
               clear                 = 1'b1;
            end
         end
         MODE_BASIC: begin
            // Decode the header bytes
            if (header_ff == 3'd0) begin
               priority if (in_byte == CHAR_ACTION) begin
                  kind_in = KIND_ACTION;
               end else if (in_byte == CHAR_REPLY) begin
                  kind_in = KIND_REPLY;
               end else begin
                  kind_in = KIND_NONE;
                  bad_in  = 1'b1;
               end
            end else if (header_ff < HEADER_LEN) begin
               id_in = {id_ff[23:0], in_byte};
            end
            if (header_ff < HEADER_LEN) begin
               header_in = header_ff + 3'd1;
            end
            if (!in_last) begin
               has_result          = (header_ff >= HEADER_LEN) && !bad_ff;
               result.payload_byte = in_byte;
               result.byte_valid   = 1'b1;
               result.message_kind = kind_ff;
               result.message_id   = id_ff;
            end else begin
               has_result            = 1'b1;
               result.end_of_message = 1'b1;
               clear                 = 1'b1;
               priority if (header_ff < HEADER_LAST) begin
                  result.error_code = ERR_SHORT;
               end else if (bad_in) begin
                  result.error_code = ERR_TYPE;
               end else if (header_ff == HEADER_LAST) begin
                  result.message_kind = kind_in;
                  result.message_id   = id_in;
               end else begin
                  result.payload_byte = in_byte;
                  result.byte_valid   = 1'b1;
                  result.message_kind = kind_ff;
                  result.message_id   = id_ff;
               end
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   // Hold mode; a mode write or a message end clears the message state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_DIRECT;
         held0_ff      <= '0;
         held1_ff      <= '0;
         held_count_ff <= '0;
         header_ff     <= '0;
         kind_ff       <= KIND_NONE;
         id_ff         <= '0;
         bad_ff        <= 1'b0;
      end else if (csr_we || (in_fire && clear)) begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         held0_ff      <= '0;
         held1_ff      <= '0;
         held_count_ff <= '0;
         header_ff     <= '0;
         kind_ff       <= KIND_NONE;
         id_ff         <= '0;
         bad_ff        <= 1'b0;
      end else if (in_fire) begin
         held0_ff      <= held0_in;
         held1_ff      <= held1_in;
         held_count_ff <= held_count_in;
         header_ff     <= header_in;
         kind_ff       <= kind_in;
         id_ff         <= id_in;
         bad_ff        <= bad_in;
      end
   end

endmodule

/* design/mdf_out_stage.sv */
// Result register with a skid entry between the strip logic and the output.
module mdf_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mdf_pkg::result_type push_data,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output mdf_pkg::result_type out_data
);
   import mdf_pkg::*;
`include "message_deframer_defines.svh"

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Steer a new beat to the result register or the skid entry
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `MDF_ASSERT_SAME(a_skid_behind_main, skid_valid_ff, main_valid_ff, "skid full, main empty")
   `MDF_ASSERT_SAME(a_no_push_when_full, push, !skid_valid_ff, "beat pushed into full stage")
   `MDF_ASSERT_NEXT(a_skid_drains, skid_valid_ff && pop, main_valid_ff && !skid_valid_ff,
                    "skid entry not moved to result register")
   `MDF_ASSERT_SAME(a_error_on_end, main_valid_ff && (main_ff.error_code != ERR_NONE),
                    main_ff.end_of_message, "error code on a beat that is not the end")
   `MDF_ASSERT_SAME(a_empty_byte_zero, main_valid_ff && !main_ff.byte_valid,
                    main_ff.payload_byte == 8'd0, "empty result carries a nonzero byte")

endmodule

/* design/message_deframer.sv */
// Top level of the message deframer.
// Strips protocol framing from a byte stream: one message byte is taken per
// req beat, with req_tlast on its final byte, and at most one result beat
// comes out for it. The block takes a byte in every cycle while req_tready
// is high; a result is registered before it shows on rsp. A two-entry
// output stage (result register plus skid entry) lets a byte be
// taken while a result waits, and req_tready falls only while both entries
// hold results. Mode writes on csr_we take effect from the cycle after the write
// and abort any partly received message.
module message_deframer (
   input  logic        clock,
   input  logic        reset,
   // Configuration: protocol_mode
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   // Input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // in_last
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] payload_byte, [39:8] message_id
   output logic [4:0]  rsp_tuser,   // [0] byte_valid, [2:1] message_kind, [4:3] error_code
   output logic        rsp_tlast    // end_of_message
);
   import mdf_pkg::*;

   logic       in_fire;
   logic       has_result;
   result_type result;
   result_type out_data;

   assign in_fire = req_tvalid && req_tready;

   // Strip framing and track per-message state
   mdf_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .in_fire    (in_fire),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .has_result (has_result),
      .result     (result)
   );

   // Register results toward the consumer
   mdf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (in_fire && has_result),
      .push_data (result),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   // Pack result fields onto the stream
   assign rsp_tdata = {out_data.message_id, out_data.payload_byte};
   assign rsp_tuser = {out_data.error_code, out_data.message_kind, out_data.byte_valid};
   assign rsp_tlast = out_data.end_of_message;

endmodule

/* sim/tb_top.sv */
// Testbench for message_deframer: directed and random framing traffic checked by a local predictor.
module tb_top;
   import mdf_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 470;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 60;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tlast;   // in_last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [7:0] payload_byte, [39:8] message_id
   logic [4:0]  rsp_tuser;   // [0] byte_valid, [2:1] message_kind, [4:3] error_code
   logic        rsp_tlast;   // end_of_message

   // Predictor state: current mode, trailer delay store and basic header decode
   logic [1:0]  cur_mode;
   logic [7:0]  dly_buf [2];
   int          dly_cnt;
   int          hdr_seen;
   logic [1:0]  hdr_kind;
   logic [31:0] hdr_id;
   bit          hdr_bad;

   result_type  pending_results [$];
   logic [7:0]  msg_buf [$];

   int  err_count    = 0;
   int  bytes_sent   = 0;
   int  results_seen = 0;
   int  mode_writes  = 0;
   int  quiet_cycles = 0;
   int  hold_request = 0;
   bit  src_gaps_on;
   bit  sink_stalls_on;

   message_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      err_count++;
      if (err_count <= 40)
         $display("ERROR: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
   endtask

   // Random idle length: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      else if (r < 92)
         return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   function automatic void clear_frame_state();
      dly_buf[0] = 8'h00;
      dly_buf[1] = 8'h00;
      dly_cnt    = 0;
      hdr_seen   = 0;
      hdr_kind   = KIND_NONE;
      hdr_id     = '0;
      hdr_bad    = 1'b0;
   endfunction

   function automatic void expect_result(input logic [7:0] b, input logic valid,
                                         input logic eom, input logic [1:0] kind,
                                         input logic [31:0] id, input logic [1:0] err);
      result_type r;
      r.payload_byte   = b;
      r.byte_valid     = valid;
      r.end_of_message = eom;
      r.message_kind   = kind;
      r.message_id     = id;
      r.error_code     = err;
      pending_results.push_back(r);
   endfunction

   // Work out the result (if any) that one accepted byte causes
   function automatic void deframe_byte(input logic [7:0] b, input logic last);
      int hc;
      hc = hdr_seen;
      case (cur_mode)
         MODE_DIRECT: begin
            expect_result(b, 1'b1, last, KIND_NONE, '0, ERR_NONE);
         end
         MODE_LINE: begin
            if (!last) begin
               if (dly_cnt != 0)
                  expect_result(dly_buf[0], 1'b1, 1'b0, KIND_NONE, '0, ERR_NONE);
               dly_buf[0] = b;
               dly_cnt = 1;
            end else begin
               if (dly_cnt != 0)
                  expect_result(dly_buf[0], 1'b1, 1'b1, KIND_NONE, '0, ERR_NONE);
               else
                  expect_result(8'h00, 1'b0, 1'b1, KIND_NONE, '0, ERR_NONE);
               clear_frame_state();
            end
         end
         MODE_TELNET: begin
            if (!last) begin
               if (dly_cnt >= 2) begin
                  expect_result(dly_buf[0], 1'b1, 1'b0, KIND_NONE, '0, ERR_NONE);
                  dly_buf[0] = dly_buf[1];
                  dly_buf[1] = b;
               end else begin
                  dly_buf[dly_cnt] = b;
                  dly_cnt++;
               end
            end else begin
               if (dly_cnt >= 2)
                  expect_result(dly_buf[0], 1'b1, 1'b1, KIND_NONE, '0, ERR_NONE);
               else
                  expect_result(8'h00, 1'b0, 1'b1, KIND_NONE, '0, ERR_NONE);
               clear_frame_state();
            end
         end
         default: begin
            // Decode type byte, then shift in the big-endian id
            if (hc == 0) begin
               if (b == CHAR_ACTION)
                  hdr_kind = KIND_ACTION;
               else if (b == CHAR_REPLY)
                  hdr_kind = KIND_REPLY;
               else begin
                  hdr_kind = KIND_NONE;
                  hdr_bad  = 1'b1;
               end
            end else if (hc < int'(HEADER_LEN)) begin
               hdr_id = {hdr_id[23:0], b};
            end
            if (hc < int'(HEADER_LEN))
               hdr_seen = hc + 1;

            if (!last) begin
               if (hc >= int'(HEADER_LEN) && !hdr_bad)
                  expect_result(b, 1'b1, 1'b0, hdr_kind, hdr_id, ERR_NONE);
            end else begin
               if (hc + 1 < int'(HEADER_LEN))
                  expect_result(8'h00, 1'b0, 1'b1, KIND_NONE, '0, ERR_SHORT);
               else if (hdr_bad)
                  expect_result(8'h00, 1'b0, 1'b1, KIND_NONE, '0, ERR_TYPE);
               else if (hc + 1 == int'(HEADER_LEN))
                  expect_result(8'h00, 1'b0, 1'b1, hdr_kind, hdr_id, ERR_NONE);
               else
                  expect_result(b, 1'b1, 1'b1, hdr_kind, hdr_id, ERR_NONE);
               clear_frame_state();
            end
         end
      endcase
   endfunction

   // Offer one byte, hold it until accepted, then predict its result
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = (src_gaps_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      deframe_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_msg_buf(input bit complete);
      foreach (msg_buf[i])
         send_byte(msg_buf[i], complete && (i == msg_buf.size() - 1));
   endtask

   // Stop offering and wait until every expected result has come
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_mode(input logic [1:0] mode);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_mode = mode;
      clear_frame_state();
      mode_writes++;
   endtask

   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return 8'h00;
      else if (r < 16)
         return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic int rand_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12)
         return $urandom_range(1, 4);
      else if (r < 88)
         return $urandom_range(5, 14);
      return $urandom_range(15, 40);
   endfunction

   // Fill msg_buf; basic messages mostly get a valid type byte
   function automatic void build_message(input logic [1:0] mode, input int len);
      msg_buf.delete();
      for (int i = 0; i < len; i++)
         msg_buf.push_back(rand_byte());
      if (mode == MODE_BASIC && $urandom_range(0, 99) < 85)
         msg_buf[0] = ($urandom_range(0, 1) == 1) ? CHAR_ACTION : CHAR_REPLY;
   endfunction

   task automatic test_direct_mode();
      set_mode(MODE_DIRECT);
      msg_buf = '{8'h00, 8'hFF};
      send_msg_buf(1'b1);
   endtask

   task automatic test_line_mode();
      set_mode(MODE_LINE);
      // single byte: nothing left after stripping
      msg_buf = '{8'hA5};
      send_msg_buf(1'b1);
      msg_buf = '{8'h01, 8'h02, 8'hFE};
      send_msg_buf(1'b1);
   endtask

   task automatic test_telnet_mode();
      set_mode(MODE_TELNET);
      // two bytes: empty payload
      msg_buf = '{8'h11, 8'h22};
      send_msg_buf(1'b1);
      msg_buf = '{8'h80, 8'h7F, 8'h01};
      send_msg_buf(1'b1);
   endtask

   task automatic test_basic_mode();
      set_mode(MODE_BASIC);
      // action with all-ones id and one payload byte
      msg_buf = '{CHAR_ACTION, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_msg_buf(1'b1);
      // reply with header only
      msg_buf = '{CHAR_REPLY, 8'h00, 8'h00, 8'h00, 8'h00};
      send_msg_buf(1'b1);
      // too short with a bad type byte: short wins
      msg_buf = '{8'h00, 8'hFF};
      send_msg_buf(1'b1);
      // bad type with payload: payload dropped, type error on end
      msg_buf = '{8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC};
      send_msg_buf(1'b1);
   endtask

   task automatic test_mode_abort();
      set_mode(MODE_LINE);
      msg_buf = '{8'h55};
      send_msg_buf(1'b0);
      // rewrite the mode: held byte must be gone
      set_mode(MODE_LINE);
      msg_buf = '{8'hAA};
      send_msg_buf(1'b1);
   endtask

   task automatic test_sender_pause();
      set_mode(MODE_BASIC);
      msg_buf = '{CHAR_REPLY, 8'h00, 8'h00, 8'h01, 8'h00, 8'hC3};
      send_msg_buf(1'b0);
      wait_drained();
      msg_buf = '{8'h3C};
      send_msg_buf(1'b1);
   endtask

   task automatic test_output_backpressure();
      set_mode(MODE_DIRECT);
      src_gaps_on  = 1'b0;
      hold_request = HOLD_CYCLES;
      build_message(MODE_DIRECT, 16);
      send_msg_buf(1'b1);
      wait_drained();
      src_gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int         start_count;
      int         phase;
      logic [1:0] mode;
      start_count = bytes_sent;
      phase = 0;
      while (bytes_sent - start_count < RANDOM_ITEMS) begin
         mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
         src_gaps_on    = ($urandom_range(0, 3) != 0);
         sink_stalls_on = ($urandom_range(0, 3) != 0);
         set_mode(mode);
         repeat ($urandom_range(3, 8)) begin
            build_message(mode, rand_length());
            send_msg_buf(1'b1);
         end
         // sometimes leave a message unfinished for the next mode write
         if ($urandom_range(0, 4) == 0) begin
            build_message(mode, $urandom_range(1, 6));
            send_msg_buf(1'b0);
         end
         phase++;
      end
   endtask

   // Result sink pacing: requested long hold, else random stalls
   always @(negedge clock) begin : sink_pacing
      int hold_left;
      int stall_left;
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (sink_stalls_on && $urandom_range(0, 99) < 30) begin
         rsp_tready <= 1'b0;
         stall_left = pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_error($sformatf("result %0d arrived with none expected", results_seen));
         end else begin
            want = pending_results.pop_front();
            check_field("payload_byte", rsp_tdata[7:0], want.payload_byte);
            check_field("byte_valid", rsp_tuser[0], want.byte_valid);
            check_field("end_of_message", rsp_tlast, want.end_of_message);
            check_field("message_kind", rsp_tuser[2:1], want.message_kind);
            check_field("message_id", rsp_tdata[39:8], want.message_id);
            check_field("error_code", rsp_tuser[4:3], want.error_code);
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout after %0d quiet cycles, %0d results still expected",
                  quiet_cycles, pending_results.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = MODE_DIRECT;
      req_tvalid     = 1'b0;
      req_tdata      = 8'h00;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      src_gaps_on    = 1'b1;
      sink_stalls_on = 1'b1;
      cur_mode       = MODE_DIRECT;
      clear_frame_state();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_direct_mode();
      test_line_mode();
      test_telnet_mode();
      test_basic_mode();
      test_mode_abort();
      test_sender_pause();
      test_output_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d message bytes, checked %0d results, %0d mode writes.",
               bytes_sent, results_seen, mode_writes);
      $display("Covered direct, line, telnet and basic framing with short, bad-type and %s",
               "aborted messages under stalls.");
      if (err_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/mdf_pkg.sv
design/mdf_frame.sv
design/mdf_out_stage.sv
design/message_deframer.sv
sim/tb_top.sv
